// ----- rtl/sbrm_pkg.sv -----
// shared types and constants for the stereo band rms meter
// used by every rtl file of the block; depends on nothing

package sbrm_pkg;

	localparam int SAMPLE_W   = 24;
	localparam int RMS_W      = 25;
	localparam int SUM_W      = 64;
	localparam int BAND_W     = 28;
	localparam int LP_W       = 32;
	localparam int COEFF_W    = 16;
	localparam int DATA_W     = 32;
	localparam int ADDR_W     = 3;
	localparam int NUM_BANDS  = 4;

	localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd65208;

	// register index, taken from paddr above the byte offset
	localparam logic [ADDR_W-3:0] REG_LOW_POLE = 1'b0;

	// band lanes
	localparam int BAND_LOW   = 0;
	localparam int BAND_MID   = 1;
	localparam int BAND_HIGH  = 2;
	localparam int BAND_BROAD = 3;

	// shift-subtract divider and digit-by-digit root
	localparam int DIV_STEPS  = SUM_W;
	localparam int ROOT_STEPS = SUM_W / 2;
	localparam int ROOT_W     = SUM_W / 2;
	localparam int SQREM_W    = ROOT_W + 2;
	localparam int ITER_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic mul_en;
		logic upd_en;
	} pole_ctl_t;

	typedef struct packed {
		logic sq_en;
		logic acc_en;
		logic root_start;
	} band_ctl_t;

endpackage

// ----- rtl/sbrm_if.sv -----
// valid/ready channel interfaces for samples in and levels out
// uses sbrm_pkg for field widths

interface sbrm_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sbrm_pkg::SAMPLE_W-1:0] left_sample;
	logic signed [sbrm_pkg::SAMPLE_W-1:0] right_sample;
	logic                                 left_present;
	logic                                 right_present;
	logic                                 block_end;

	modport source (output valid, left_sample, right_sample, left_present, right_present,
		block_end, input ready);
	modport sink (input valid, left_sample, right_sample, left_present, right_present,
		block_end, output ready);
endinterface

interface sbrm_out_if;
	logic                         valid;
	logic                         ready;
	logic [sbrm_pkg::RMS_W-1:0]   low_rms;
	logic [sbrm_pkg::RMS_W-1:0]   mid_rms;
	logic [sbrm_pkg::RMS_W-1:0]   high_rms;
	logic [sbrm_pkg::RMS_W-1:0]   broad_rms;
	logic                         block_overflow;

	modport source (output valid, low_rms, mid_rms, high_rms, broad_rms, block_overflow,
		input ready);
	modport sink (input valid, low_rms, mid_rms, high_rms, broad_rms, block_overflow,
		output ready);
endinterface

// ----- rtl/sbrm_pole.sv -----
// one-pole lowpass lane, one per channel, state in signed q1.31
// uses sbrm_pkg; two products in the first step, rounded sum in the second

module sbrm_pole (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sbrm_pkg::pole_ctl_t                  ctl,
	input  logic [sbrm_pkg::COEFF_W-1:0]         coeff,
	input  logic signed [sbrm_pkg::SAMPLE_W-1:0] sample,
	output logic signed [sbrm_pkg::LP_W-1:0]     state
);

	localparam int PROD_W = sbrm_pkg::LP_W + 18;

	logic signed [16:0]         a_s;
	logic signed [17:0]         b_s;
	logic signed [31:0]         x_s;
	logic signed [PROD_W-1:0]   pa;
	logic signed [PROD_W-1:0]   pb;
	logic signed [PROD_W-1:0]   prod_a_s1;
	logic signed [PROD_W-1:0]   prod_b_s1;
	logic signed [PROD_W:0]     acc;
	logic signed [sbrm_pkg::LP_W-1:0] lp_q;

	assign a_s = $signed({1'b0, coeff});
	// 65536 - a needs a full 17 magnitude bits when a is zero
	assign b_s = 18'sd65536 - $signed({2'b00, coeff});
	assign x_s = $signed({sample, 8'h00});
	assign pa  = a_s * lp_q;
	assign pb  = b_s * x_s;
	assign acc = (PROD_W+1)'(prod_a_s1) + (PROD_W+1)'(prod_b_s1) + (PROD_W+1)'(32768);

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_a_s1 <= pa;
			prod_b_s1 <= pb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q <= '0;
		end else if (ctl.upd_en) begin
			lp_q <= acc[47:16];
		end
	end

	assign state = lp_q;

endmodule

// ----- rtl/sbrm_band_lane.sv -----
// band lane: square, saturating energy sum, then mean and root at block end
// uses sbrm_pkg; the root steps one bit pair per cycle, the divider one quotient bit at a time

module sbrm_band_lane #(
	parameter int CNT_W = 13
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sbrm_pkg::band_ctl_t                ctl,
	input  logic signed [sbrm_pkg::BAND_W-1:0] band,
	input  logic [CNT_W-1:0]                   count,
	output logic [sbrm_pkg::RMS_W-1:0]         rms,
	output logic                               done
);

	localparam int SUM_W  = sbrm_pkg::SUM_W;
	localparam int BAND_W = sbrm_pkg::BAND_W;
	localparam int ROOT_W = sbrm_pkg::ROOT_W;
	localparam int SQR_W  = sbrm_pkg::SQREM_W;
	localparam int ITW    = sbrm_pkg::ITER_W;
	localparam logic [ITW-1:0] DIV_LAST  = ITW'(sbrm_pkg::DIV_STEPS - 1);
	localparam logic [ITW-1:0] ROOT_LAST = ITW'(sbrm_pkg::ROOT_STEPS - 1);

	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_DIV  = 3'b010,
		L_ROOT = 3'b100
	} lane_state_t;

	lane_state_t              st_q;
	logic [ITW-1:0]           iter_q;
	logic [BAND_W-1:0]        mag;
	logic [2*BAND_W-1:0]      sq_s1;
	logic [SUM_W-1:0]         sum_q;
	logic [SUM_W:0]           sum_ext;
	logic [SUM_W-1:0]         work_q;
	logic [CNT_W-1:0]         dv_q;
	logic [CNT_W-1:0]         div_rem_q;
	logic [CNT_W:0]           trial;
	logic [CNT_W:0]           diff;
	logic                     qbit;
	logic [SUM_W-1:0]         quot;
	logic [SQR_W-1:0]         sq_rem_q;
	logic [SQR_W+1:0]         rem_sh;
	logic [SQR_W+1:0]         rtrial;
	logic                     rbit;
	logic [ROOT_W-1:0]        root_q;
	logic [ROOT_W-1:0]        root_next;
	logic [sbrm_pkg::RMS_W-1:0] rms_q;
	logic                     done_q;

	assign mag     = band[BAND_W-1] ? BAND_W'(-band) : BAND_W'(band);
	assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(sq_s1);

	assign trial = {div_rem_q, work_q[SUM_W-1]};
	assign qbit  = trial >= {1'b0, dv_q};
	assign diff  = trial - {1'b0, dv_q};
	assign quot  = {work_q[SUM_W-2:0], qbit};

	assign rem_sh    = {sq_rem_q, work_q[SUM_W-1:SUM_W-2]};
	assign rtrial    = {2'b00, root_q, 2'b01};
	assign rbit      = rem_sh >= rtrial;
	assign root_next = {root_q[ROOT_W-2:0], rbit};

	always_ff @(posedge clk) begin
		if (ctl.sq_en) begin
			sq_s1 <= mag * mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.root_start) begin
			sum_q <= '0;
		end else if (ctl.acc_en) begin
			sum_q <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= L_IDLE;
			iter_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				L_IDLE: begin
					if (ctl.root_start) begin
						st_q   <= L_DIV;
						iter_q <= '0;
					end
				end
				L_DIV: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == DIV_LAST) begin
						st_q   <= L_ROOT;
						iter_q <= '0;
					end
				end
				L_ROOT: begin
					iter_q <= iter_q + 1'b1;
					if (iter_q == ROOT_LAST) begin
						st_q   <= L_IDLE;
						done_q <= 1'b1;
					end
				end
				default: begin
					st_q <= L_IDLE;
				end
			endcase
		end
	end

	// datapath of the divider and the root
	always_ff @(posedge clk) begin
		unique case (st_q)
			L_IDLE: begin
				if (ctl.root_start) begin
					work_q    <= sum_q;
					dv_q      <= count;
					div_rem_q <= '0;
				end
			end
			L_DIV: begin
				div_rem_q <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
				if (iter_q == DIV_LAST) begin
					// mean / 4 becomes the radicand
					work_q   <= {2'b00, quot[SUM_W-1:2]};
					sq_rem_q <= '0;
					root_q   <= '0;
				end else begin
					work_q <= quot;
				end
			end
			L_ROOT: begin
				sq_rem_q <= rbit ? SQR_W'(rem_sh - rtrial) : rem_sh[SQR_W-1:0];
				root_q   <= root_next;
				work_q   <= {work_q[SUM_W-3:0], 2'b00};
				if (iter_q == ROOT_LAST) begin
					rms_q <= (|root_next[ROOT_W-1:sbrm_pkg::RMS_W]) ? '1
						: root_next[sbrm_pkg::RMS_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign rms  = rms_q;
	assign done = done_q;

endmodule

// ----- rtl/stereo_band_rms_meter_top.sv -----
// stereo band rms meter: per-sample filtering, band split and energy sums,
// rms of four bands at the end of each block
// uses sbrm_pkg, sbrm_if, sbrm_pole and sbrm_band_lane
//
// samples: valid/ready channel, one stereo sample per transaction; block_end
//   marks the last sample of an analysis block
// levels: valid/ready channel, one transaction per block with four rms values
//   in unsigned q2.23 and the overflow flag
// apb port: register 0 at address 0 holds the lowpass pole (reset 0.995)
// a sample passes these steps from acceptance until the next one can be taken:
//   two channel lowpass lanes, band split, four squaring lanes, accumulate
// a block_end sample then goes on to start, root and emit: each band lane runs a 64-step
//   shift-subtract divide by the sample count and a 32-step root; its level
//   is presented once the level register is free
// after reset the filter state, sums and count are zero and no level waits
// the level register parts the two sides: samples keep flowing while a level
//   waits; only a second level stalls until the first is taken

module stereo_band_rms_meter_top #(
	parameter int MAX_BLOCK = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sbrm_pkg::ADDR_W-1:0]   paddr,
	input  logic [sbrm_pkg::DATA_W-1:0]   pwdata,
	output logic [sbrm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	sbrm_in_if.sink                       samples,
	sbrm_out_if.source                    levels
);

	localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
	localparam int BAND_W = sbrm_pkg::BAND_W;
	localparam int SW     = sbrm_pkg::SAMPLE_W;
	localparam int NB     = sbrm_pkg::NUM_BANDS;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_PMUL  = 9'b000000010,
		S_PSUM  = 9'b000000100,
		S_BAND  = 9'b000001000,
		S_SQR   = 9'b000010000,
		S_ACC   = 9'b000100000,
		S_START = 9'b001000000,
		S_ROOT  = 9'b010000000,
		S_EMIT  = 9'b100000000
	} meter_state_t;

	meter_state_t                   st_q;
	logic [sbrm_pkg::COEFF_W-1:0]   coeff_q;
	logic                           cfg_wr;
	logic signed [SW-1:0]           left_q;
	logic signed [SW-1:0]           right_q;
	logic signed [SW-1:0]           left_in;
	logic                           end_q;
	logic signed [SW-1:0]           prev_left_q;
	logic signed [SW-1:0]           prev_right_q;
	logic [CNT_W-1:0]               count_q;
	logic                           ovf_q;
	logic                           ovf_res_q;
	logic                           ovf_out_q;
	logic                           out_valid_q;
	logic [sbrm_pkg::RMS_W-1:0]     out_rms_q [NB];
	logic                           load_out;
	sbrm_pkg::pole_ctl_t            pole_ctl;
	sbrm_pkg::band_ctl_t            band_ctl;
	logic signed [sbrm_pkg::LP_W-1:0] lp_left;
	logic signed [sbrm_pkg::LP_W-1:0] lp_right;
	logic signed [BAND_W-1:0]       band_q [NB];
	logic [sbrm_pkg::RMS_W-1:0]     lane_rms [NB];
	logic [NB-1:0]                  lane_done;
	logic signed [BAND_W-1:0]       mono;
	logic signed [33:0]             lp_sum;
	logic signed [33:0]             low_full;
	logic signed [BAND_W-1:0]       low;
	logic signed [BAND_W-1:0]       high;
	logic signed [BAND_W-1:0]       high_q4;
	logic signed [BAND_W-1:0]       mid;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite
		&& (paddr[sbrm_pkg::ADDR_W-1:2] == sbrm_pkg::REG_LOW_POLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= sbrm_pkg::COEFF_RESET;
		end else if (cfg_wr) begin
			coeff_q <= pwdata[sbrm_pkg::COEFF_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[sbrm_pkg::ADDR_W-1:2] == sbrm_pkg::REG_LOW_POLE) begin
			prdata = sbrm_pkg::DATA_W'(coeff_q);
		end
	end

	// control sequencer
	assign samples.ready = (st_q == S_IDLE);
	assign load_out      = (st_q == S_EMIT) && (!out_valid_q || levels.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			unique case (st_q)
				S_IDLE:  if (samples.valid) st_q <= S_PMUL;
				S_PMUL:  st_q <= S_PSUM;
				S_PSUM:  st_q <= S_BAND;
				S_BAND:  st_q <= S_SQR;
				S_SQR:   st_q <= S_ACC;
				S_ACC:   st_q <= end_q ? S_START : S_IDLE;
				S_START: st_q <= S_ROOT;
				S_ROOT:  if (&lane_done) st_q <= S_EMIT;
				S_EMIT:  if (load_out) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign pole_ctl.mul_en     = (st_q == S_PMUL);
	assign pole_ctl.upd_en     = (st_q == S_PSUM);
	assign band_ctl.sq_en      = (st_q == S_SQR);
	assign band_ctl.acc_en     = (st_q == S_ACC);
	assign band_ctl.root_start = (st_q == S_START);

	// input capture: missing left reads zero, missing right copies left
	assign left_in = samples.left_present ? samples.left_sample : '0;

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			left_q  <= left_in;
			right_q <= samples.right_present ? samples.right_sample : left_in;
			end_q   <= samples.block_end;
		end
	end

	sbrm_pole u_pole_left (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pole_ctl),
		.coeff  (coeff_q),
		.sample (left_q),
		.state  (lp_left)
	);

	sbrm_pole u_pole_right (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pole_ctl),
		.coeff  (coeff_q),
		.sample (right_q),
		.state  (lp_right)
	);

	// band split, all in units of 2^-24
	assign mono     = BAND_W'(left_q) + BAND_W'(right_q);
	assign lp_sum   = 34'(lp_left) + 34'(lp_right) + 34'sd128;
	assign low_full = lp_sum >>> 8;
	assign low      = low_full[BAND_W-1:0];
	assign high     = mono - (BAND_W'(prev_left_q) + BAND_W'(prev_right_q));
	assign high_q4  = (high + BAND_W'(2)) >>> 2;
	assign mid      = mono - low - high_q4;

	always_ff @(posedge clk) begin
		if (st_q == S_BAND) begin
			band_q[sbrm_pkg::BAND_LOW]   <= low;
			band_q[sbrm_pkg::BAND_MID]   <= mid;
			band_q[sbrm_pkg::BAND_HIGH]  <= high;
			band_q[sbrm_pkg::BAND_BROAD] <= mono;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_left_q  <= '0;
			prev_right_q <= '0;
		end else if (st_q == S_BAND) begin
			prev_left_q  <= left_q;
			prev_right_q <= right_q;
		end
	end

	// sample count saturates at the block limit and flags the excess
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ovf_q     <= 1'b0;
			ovf_res_q <= 1'b0;
		end else if (st_q == S_ACC) begin
			if (count_q < CNT_W'(MAX_BLOCK)) begin
				count_q <= count_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end else if (st_q == S_START) begin
			ovf_res_q <= ovf_q;
			ovf_q     <= 1'b0;
			count_q   <= '0;
		end
	end

	for (genvar g = 0; g < NB; g++) begin : g_lane
		sbrm_band_lane #(
			.CNT_W (CNT_W)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (band_ctl),
			.band   (band_q[g]),
			.count  (count_q),
			.rms    (lane_rms[g]),
			.done   (lane_done[g])
		);
	end

	// merge: level register holding one finished transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (levels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_rms_q <= lane_rms;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			ovf_out_q <= ovf_res_q;
		end
	end

	assign levels.valid          = out_valid_q;
	assign levels.low_rms        = out_rms_q[sbrm_pkg::BAND_LOW];
	assign levels.mid_rms        = out_rms_q[sbrm_pkg::BAND_MID];
	assign levels.high_rms       = out_rms_q[sbrm_pkg::BAND_HIGH];
	assign levels.broad_rms      = out_rms_q[sbrm_pkg::BAND_BROAD];
	assign levels.block_overflow = ovf_out_q;

`ifndef ASSERT_OFF
	// the lanes share one start and fixed step counts, so they finish together
	assert property (@(posedge clk) disable iff (!arst_n)
		(|lane_done) |-> (&lane_done))
		else $error("band lanes finished out of step");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BLOCK))
		else $error("sample count beyond block limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> out_valid_q && (st_q == S_IDLE))
		else $error("level not presented after merge");

	// roots only come back while the sequencer waits for them
	assert property (@(posedge clk) disable iff (!arst_n)
		(|lane_done) |-> (st_q == S_ROOT))
		else $error("root result outside the root phase");
`endif

endmodule
